@@ src/dq_pkg.sv @@
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue: operation and status
// codes, controller states and the controller-to-datapath command group.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int MODE_W   = 3;
  localparam int FIELD_W  = 32;
  localparam int POS_W    = 7;
  localparam int COUNT_OW = 8;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ       = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_OUT_RANGE = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ENDS,
    ST_POS,
    ST_DONE
  } dq_state_t;

  typedef struct packed {
    logic take;      // latch the incoming transaction
    logic exec;      // apply the operation to pointers and ring
    logic rd_ends;   // read front and back slots
    logic rd_pos;    // read the requested position
    logic load_out;  // move the finished result into the output register
  } dq_cmd_t;

endpackage

@@ src/dq_ctrl.sv @@
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer for one operation: accept, execute, read ends, read position,
// hand off to the output register. Owns both stream handshakes.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output dq_pkg::dq_cmd_t cmd
);
  import dq_pkg::*;

  dq_state_t state;
  dq_state_t state_next;
  logic      out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: state_next = ST_ENDS;
      ST_ENDS: state_next = ST_POS;
      ST_POS:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_EXEC: cmd.exec = 1'b1;
      ST_ENDS: cmd.rd_ends = 1'b1;
      ST_POS:  cmd.rd_pos = 1'b1;
      ST_DONE: cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ src/dq_datapath.sv @@
// ----------------------------------------------------------------------------
// dq_datapath
// Ring memory with head slot and occupancy, operation register, read
// registers and the output result register.
// ----------------------------------------------------------------------------
module dq_datapath #(
  parameter int CAPACITY  = 128,
  parameter int WORD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dq_pkg::dq_cmd_t                cmd,
  input  logic [dq_pkg::MODE_W-1:0]      mode,
  input  logic signed [dq_pkg::FIELD_W-1:0] value,
  input  logic [dq_pkg::POS_W-1:0]       position,
  output logic signed [dq_pkg::FIELD_W-1:0] front_value,
  output logic signed [dq_pkg::FIELD_W-1:0] back_value,
  output logic signed [dq_pkg::FIELD_W-1:0] read_value,
  output logic [dq_pkg::COUNT_OW-1:0]    count,
  output logic                           is_empty,
  output logic [dq_pkg::STATUS_W-1:0]    status
);
  import dq_pkg::*;

  localparam int SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W = $clog2(CAPACITY + 1);

  logic [WORD_BITS-1:0] ring [CAPACITY];

  logic [SLOT_W-1:0]    head;
  logic [SLOT_W-1:0]    head_next;
  logic [COUNT_W-1:0]   occ;
  logic [COUNT_W-1:0]   occ_next;

  logic [MODE_W-1:0]    op_mode;
  logic [FIELD_W-1:0]   op_value;
  logic [POS_W-1:0]     op_pos;
  logic [STATUS_W-1:0]  op_status;
  logic [STATUS_W-1:0]  status_next;
  logic                 hit;

  logic                 wr_en;
  logic [SLOT_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic [WORD_BITS-1:0] rd_a;
  logic [WORD_BITS-1:0] rd_b;
  logic [WORD_BITS-1:0] front_q;
  logic [SLOT_W-1:0]    rd_addr_a;
  logic [SLOT_W-1:0]    back_slot;
  logic [SLOT_W-1:0]    pos_slot;
  logic [SLOT_W-1:0]    tail_slot;
  logic [SLOT_W-1:0]    head_inc;
  logic [SLOT_W-1:0]    head_dec;
  logic [COUNT_W-1:0]   occ_dec;
  logic [63:0]          value64;
  logic [31:0]          pos32;
  logic [31:0]          occ32;
  logic [63:0]          front64;
  logic [63:0]          back64;
  logic [63:0]          read64;
  logic                 full;
  logic                 empty;

  // Ring index of head plus an offset below CAPACITY
  function automatic logic [SLOT_W-1:0] wrap_add(input logic [SLOT_W-1:0] base,
                                                 input logic [SLOT_W-1:0] offs);
    logic [SLOT_W:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= (SLOT_W+1)'(CAPACITY)) begin
      sum = sum - (SLOT_W+1)'(CAPACITY);
    end
    return sum[SLOT_W-1:0];
  endfunction

  assign full     = (occ == COUNT_W'(CAPACITY));
  assign empty    = (occ == '0);
  assign occ_dec  = occ - COUNT_W'(1);
  assign pos32    = 32'(op_pos);
  assign occ32    = 32'(occ);
  assign value64  = {32'b0, op_value};
  assign head_inc = (head == SLOT_W'(CAPACITY - 1)) ? '0 : head + SLOT_W'(1);
  assign head_dec = (head == '0) ? SLOT_W'(CAPACITY - 1) : head - SLOT_W'(1);
  assign tail_slot = wrap_add(head, occ[SLOT_W-1:0]);
  assign back_slot = wrap_add(head, occ_dec[SLOT_W-1:0]);
  assign pos_slot  = wrap_add(head, pos32[SLOT_W-1:0]);
  assign wr_data   = value64[WORD_BITS-1:0];

  always_comb begin
    head_next   = head;
    occ_next    = occ;
    status_next = STATUS_OK;
    wr_en       = 1'b0;
    wr_addr     = tail_slot;
    unique case (op_mode)
      MODE_PUSH_FRONT: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          head_next = head_dec;
          occ_next  = occ + COUNT_W'(1);
          wr_en     = cmd.exec;
          wr_addr   = head_dec;
        end
      end
      MODE_PUSH_BACK: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          occ_next = occ + COUNT_W'(1);
          wr_en    = cmd.exec;
        end
      end
      MODE_POP_FRONT: begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          head_next = head_inc;
          occ_next  = occ_dec;
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          occ_next = occ_dec;
        end
      end
      MODE_READ: begin
        if (pos32 >= occ32) status_next = STATUS_OUT_RANGE;
      end
      default: status_next = STATUS_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      occ  <= '0;
    end else if (cmd.exec) begin
      head <= head_next;
      occ  <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_mode  <= mode;
      op_value <= value;
      op_pos   <= position;
    end
    if (cmd.exec) begin
      op_status <= status_next;
      hit       <= (op_mode == MODE_READ) && (pos32 < occ32);
    end
  end

  assign rd_addr_a = cmd.rd_pos ? pos_slot : head;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_addr] <= wr_data;
    end
    if (cmd.rd_ends || cmd.rd_pos) begin
      rd_a <= ring[rd_addr_a];
    end
    if (cmd.rd_ends) begin
      rd_b <= ring[back_slot];
    end
  end

  // Keep the front word while port A goes on to the requested position
  always_ff @(posedge clk) begin
    if (cmd.rd_pos) begin
      front_q <= rd_a;
    end
  end

  assign front64 = 64'(front_q);
  assign back64  = 64'(rd_b);
  assign read64  = 64'(rd_a);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      front_value <= empty ? '0 : front64[FIELD_W-1:0];
      back_value  <= empty ? '0 : back64[FIELD_W-1:0];
      read_value  <= hit ? read64[FIELD_W-1:0] : '0;
      count       <= occ32[COUNT_OW-1:0];
      is_empty    <= empty;
      status      <= op_status;
    end
  end

endmodule

@@ src/double_ended_queue.sv @@
// Each accepted operation passes the execute, end-read, position-read and done states
//   before its result is registered on the master side, walking the single ring memory
//   through a write, a front/back read and a position read in turn, one operation at a time.
// The output register lets the next transaction enter while a result waits.
// Reset clears head slot, occupancy and handshake state; ring contents stay
//   undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
// double_ended_queue
// Fixed-capacity deque of signed words on a circular ring: push/pop at either
// end and read by position, one result per transaction.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int CAPACITY  = 128,
  parameter int WORD_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // value[31:0], position[38:32], zero pad
  input  logic [2:0]   s_axis_tuser,   // mode[2:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // front_value[31:0], back_value[63:32], read_value[95:64], count[103:96],
  // is_empty[104], status[106:105], zero pad
  output logic [111:0] m_axis_tdata
);
  import dq_pkg::*;

  dq_cmd_t                    cmd;
  logic signed [FIELD_W-1:0]  front_value;
  logic signed [FIELD_W-1:0]  back_value;
  logic signed [FIELD_W-1:0]  read_value;
  logic [COUNT_OW-1:0]        count;
  logic                       is_empty;
  logic [STATUS_W-1:0]        status;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  dq_datapath #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (s_axis_tuser),
    .value       (s_axis_tdata[31:0]),
    .position    (s_axis_tdata[38:32]),
    .front_value (front_value),
    .back_value  (back_value),
    .read_value  (read_value),
    .count       (count),
    .is_empty    (is_empty),
    .status      (status)
  );

  assign m_axis_tdata = {5'b0, status, is_empty, count, read_value, back_value, front_value};

endmodule

@@ tb/sv/deque_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_checker
// Watches both stream channels of the deque, keeps its own ring, head and
// fill count, predicts one result per accepted operation and compares every
// returned result field by field in arrival order.
// ----------------------------------------------------------------------------
module deque_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // value[31:0], position[38:32], zero pad
  input  logic [2:0]   s_axis_tuser,   // mode[2:0]
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // front_value[31:0], back_value[63:32], read_value[95:64], count[103:96],
  // is_empty[104], status[106:105], zero pad
  input  logic [111:0] m_axis_tdata,
  output int           mismatches,
  output int           outstanding
);
  import dq_pkg::*;

  localparam int DEPTH      = 128;
  localparam int PEND_DEPTH = 64;

  typedef struct packed {
    logic signed [31:0] front;
    logic signed [31:0] back;
    logic signed [31:0] rd;
    logic [7:0]         count;
    logic               empty;
    logic [1:0]         status;
  } deque_result_t;

  logic signed [31:0] ring [DEPTH];
  logic [6:0]         head;
  logic [7:0]         fill;
  deque_result_t      pend [PEND_DEPTH];
  int                 pend_wr;
  int                 pend_rd;

  function automatic deque_result_t apply_deque_op(input logic [2:0] mode,
                                                   input logic signed [31:0] word,
                                                   input logic [6:0] pos);
    deque_result_t r;
    r = '0;
    case (mode)
      MODE_PUSH_FRONT: begin
        if (fill == 8'(DEPTH)) begin
          r.status = STATUS_FULL;
        end else begin
          head = head - 7'd1;
          ring[head] = word;
          fill = fill + 8'd1;
        end
      end
      MODE_PUSH_BACK: begin
        if (fill == 8'(DEPTH)) begin
          r.status = STATUS_FULL;
        end else begin
          ring[head + fill[6:0]] = word;
          fill = fill + 8'd1;
        end
      end
      MODE_POP_FRONT: begin
        if (fill == 8'd0) begin
          r.status = STATUS_EMPTY;
        end else begin
          head = head + 7'd1;
          fill = fill - 8'd1;
        end
      end
      MODE_POP_BACK: begin
        if (fill == 8'd0) begin
          r.status = STATUS_EMPTY;
        end else begin
          fill = fill - 8'd1;
        end
      end
      MODE_READ: begin
        if ({1'b0, pos} < fill) begin
          r.rd = ring[head + pos];
        end else begin
          r.status = STATUS_OUT_RANGE;
        end
      end
      default: ;  // unused modes leave the queue alone
    endcase
    // a full ring has fill[6:0] == 0, so the back slot wraps to head - 1
    if (fill != 8'd0) begin
      r.front = ring[head];
      r.back  = ring[head + fill[6:0] - 7'd1];
    end
    r.count = fill;
    r.empty = (fill == 8'd0);
    return r;
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    deque_result_t want;
    if (rst) begin
      pend_wr = 0;
      pend_rd = 0;
      head = '0;
      fill = '0;
      outstanding <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pend_wr == pend_rd) begin
          $error("result transaction with nothing outstanding");
          mismatches++;
        end else begin
          want = pend[pend_rd % PEND_DEPTH];
          pend_rd++;
          check_field("front_value", want.front, $signed(m_axis_tdata[31:0]));
          check_field("back_value", want.back, $signed(m_axis_tdata[63:32]));
          check_field("read_value", want.rd, $signed(m_axis_tdata[95:64]));
          check_field("count", want.count, m_axis_tdata[103:96]);
          check_field("is_empty", want.empty, m_axis_tdata[104]);
          check_field("status", want.status, m_axis_tdata[106:105]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pend[pend_wr % PEND_DEPTH] = apply_deque_op(s_axis_tuser, s_axis_tdata[31:0],
                                                    s_axis_tdata[38:32]);
        pend_wr++;
      end
      outstanding <= pend_wr - pend_rd;
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the double-ended queue: a directed pass over empty, wrap and
// boundary cases, then fill, drain and mixed phases of random operations with
// random idling on both channels and long receiver hold-offs.
// ----------------------------------------------------------------------------
module tb;
  import dq_pkg::*;

  localparam int PHASES     = 8;
  localparam int PHASE_OPS  = 250;
  localparam int HOLD_CYCLES = 400;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;

  int mismatches;
  int outstanding;
  bit burst;          // no sender gaps while set
  bit long_hold_req;  // ask the receiver for one long hold-off

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  double_ended_queue u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  deque_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'h8000_0000;
    if (r < 6) return 32'h7fff_ffff;
    if (r < 8) return 32'hffff_ffff;
    if (r < 10) return 32'h0000_0000;
    return $urandom();
  endfunction

  function automatic logic [6:0] pick_pos();
    if ($urandom_range(0, 99) < 40) return 7'($urandom_range(0, 15));
    return 7'($urandom_range(0, 127));
  endfunction

  // push_pct / pop_pct set the direction of the phase; the rest are reads
  // and a few unused modes
  function automatic logic [2:0] pick_mode(input int push_pct, input int pop_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
    if (r < push_pct + pop_pct) return $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
    if (r < 95) return MODE_READ;
    return 3'($urandom_range(5, 7));
  endfunction

  // hold the transaction until accepted, then optionally drop valid for a gap
  task automatic send_op(input logic [2:0] mode, input logic [31:0] word,
                         input logic [6:0] pos);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {1'b0, pos, word};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : receiver
    int on_len;
    int off_len;
    int r;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      on_len = (r < 30) ? $urandom_range(1, 4) :
               (r < 80) ? $urandom_range(5, 20) : $urandom_range(50, 150);
      off_len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3)
                                             : $urandom_range(5, 30);
      m_axis_tready <= 1'b1;
      repeat (on_len) @(posedge clk);
      m_axis_tready <= 1'b0;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        off_len = HOLD_CYCLES;
      end
      repeat (off_len) @(posedge clk);
    end
  end

  initial begin : stimulus
    int push_pct;
    int pop_pct;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty queue, backward wrap of the head, extremes, out-of-range reads
    send_op(MODE_POP_FRONT, 32'h0, 7'd0);
    send_op(MODE_POP_BACK, 32'h0, 7'd0);
    send_op(MODE_READ, 32'h0, 7'd0);
    send_op(3'd5, 32'h1234_5678, 7'd9);
    send_op(MODE_PUSH_BACK, 32'h7fff_ffff, 7'd0);
    send_op(MODE_PUSH_FRONT, 32'h8000_0000, 7'd0);
    send_op(MODE_PUSH_BACK, 32'hffff_ffff, 7'd0);
    send_op(MODE_PUSH_FRONT, 32'h0000_0000, 7'd127);
    send_op(MODE_READ, 32'hffff_ffff, 7'd0);
    send_op(MODE_READ, 32'h0, 7'd3);
    send_op(MODE_READ, 32'h0, 7'd4);
    send_op(MODE_READ, 32'h0, 7'd127);
    send_op(3'd6, 32'h0, 7'd0);
    send_op(3'd7, 32'hffff_ffff, 7'd127);
    send_op(MODE_POP_BACK, 32'h0, 7'd0);
    send_op(MODE_POP_FRONT, 32'h0, 7'd0);
    send_op(MODE_READ, 32'h0, 7'd1);
    send_op(MODE_POP_BACK, 32'h0, 7'd0);
    send_op(MODE_POP_FRONT, 32'h0, 7'd0);
    send_op(MODE_POP_FRONT, 32'h0, 7'd0);
    send_op(MODE_PUSH_FRONT, 32'h5555_5555, 7'd0);
    send_op(MODE_PUSH_BACK, 32'haaaa_aaaa, 7'd0);
    send_op(MODE_READ, 32'h0, 7'd1);
    send_op(MODE_POP_FRONT, 32'h0, 7'd0);
    send_op(MODE_POP_BACK, 32'h0, 7'd0);

    // cycle fill, mixed, drain, mixed so the ring reaches full and empty often
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0:       begin push_pct = 70; pop_pct = 10; end
        2:       begin push_pct = 10; pop_pct = 70; end
        default: begin push_pct = 35; pop_pct = 35; end
      endcase
      burst = (p % 2 == 1);
      if (p == 1 || p == 4) long_hold_req = 1'b1;
      for (int i = 0; i < PHASE_OPS; i++) begin
        send_op(pick_mode(push_pct, pop_pct), pick_word(), pick_pos());
      end
    end

    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
